// ===== design/cmfd_pkg.sv =====
`timescale 1ns / 1ps
package cmfd_pkg;

  localparam int RawBits  = 16;
  localparam int FracBits = 16;

  localparam int ConfW    = 24;
  localparam int IdW      = 29;
  localparam int WordW    = 32;
  localparam int TempW    = 16;
  localparam int AccW     = 48;
  localparam int KindW    = 2;
  localparam int CfgIdxW  = 3;

  // multi-turn step: 24-bit difference plus wrap correction
  localparam int ErrW     = ConfW + 2;

  localparam int MulAW    = ErrW;
  localparam int MulBW    = ConfW;
  localparam int MulPW    = MulAW + MulBW;
  localparam int MulCntW  = $clog2(MulBW);

  localparam int DivW     = RawBits + ConfW + 1;
  localparam int DivCntW  = $clog2(DivW);

  localparam logic [RawBits:0] Denom = (RawBits + 1)'((1 << RawBits) - 1);

  localparam longint unsigned PiQ30    = 64'd3373259426;
  localparam longint unsigned TwoPiQ30 = 64'd6746518852;
  localparam longint unsigned DeadQ30  = 64'd10737418;
  localparam longint unsigned RndAdd   = 64'd1 << (29 - FracBits);

  localparam logic signed [ErrW-1:0] Pi    = ErrW'((PiQ30 + RndAdd) >> (30 - FracBits));
  localparam logic signed [ErrW-1:0] TwoPi = ErrW'((TwoPiQ30 + RndAdd) >> (30 - FracBits));
  localparam logic signed [ErrW-1:0] Dead  = ErrW'((DeadQ30 + RndAdd) >> (30 - FracBits));

  localparam logic [KindW-1:0] KindIgnored = 2'd0;
  localparam logic [KindW-1:0] KindStatus  = 2'd1;
  localparam logic [KindW-1:0] KindError   = 2'd2;

  localparam logic [4:0] TypeStatusA = 5'h02;
  localparam logic [4:0] TypeStatusB = 5'h12;
  localparam logic [4:0] TypeError   = 5'h15;

  localparam logic [CfgIdxW-1:0] RegMotorAddress = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAngleMin     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAngleSpan    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpeedMin     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpeedSpan    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTorqueMin    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTorqueSpan   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegInvGearRatio = 3'd7;

  localparam int InDataW  = 96;
  localparam int OutDataW = 168;
  localparam int OutUsedW = 3 * ConfW + TempW + ConfW + 1 + AccW;

endpackage

// ===== design/cmfd_mul_serial.sv =====
`timescale 1ns / 1ps
module cmfd_mul_serial (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [cmfd_pkg::MulAW-1:0]      mcand_i,
  input  logic        [cmfd_pkg::MulBW-1:0]      mplier_i,
  output logic                                   done_o,
  output logic signed [cmfd_pkg::MulPW-1:0]      prod_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [cmfd_pkg::MulCntW-1:0]       cnt_q, cnt_d;
  logic signed [cmfd_pkg::MulAW-1:0]  mcand_q, mcand_d;
  logic [cmfd_pkg::MulBW-1:0]         mplier_q, mplier_d;
  logic signed [cmfd_pkg::MulAW-1:0]  hi_q, hi_d;
  logic [cmfd_pkg::MulBW-1:0]         lo_q, lo_d;
  logic signed [cmfd_pkg::MulAW:0]    addend;
  logic signed [cmfd_pkg::MulAW:0]    sum;

  always_comb begin
    addend   = mplier_q[0] ? {mcand_q[cmfd_pkg::MulAW-1], mcand_q} : '0;
    sum      = {hi_q[cmfd_pkg::MulAW-1], hi_q} + addend;
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      hi_d     = '0;
      lo_d     = '0;
    end else if (busy_q) begin
      hi_d     = sum[cmfd_pkg::MulAW:1];
      lo_d     = {sum[0], lo_q[cmfd_pkg::MulBW-1:1]};
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == cmfd_pkg::MulCntW'(cmfd_pkg::MulBW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// ===== design/cmfd_div_const.sv =====
`timescale 1ns / 1ps
module cmfd_div_const (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cmfd_pkg::DivW-1:0]     dividend_i,
  output logic                          done_o,
  output logic [cmfd_pkg::DivW-1:0]     quot_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [cmfd_pkg::DivCntW-1:0]      cnt_q, cnt_d;
  logic [cmfd_pkg::DivW-1:0]         dvd_q, dvd_d;
  logic [cmfd_pkg::DivW-1:0]         quot_q, quot_d;
  logic [cmfd_pkg::RawBits-1:0]      rem_q, rem_d;
  logic [cmfd_pkg::RawBits:0]        trial;
  logic [cmfd_pkg::RawBits:0]        diff;
  logic                              ge;

  always_comb begin
    trial  = {rem_q, dvd_q[cmfd_pkg::DivW-1]};
    diff   = trial - cmfd_pkg::Denom;
    ge     = (trial >= cmfd_pkg::Denom);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      quot_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d  = dvd_q << 1;
      quot_d = {quot_q[cmfd_pkg::DivW-2:0], ge};
      rem_d  = ge ? diff[cmfd_pkg::RawBits-1:0] : trial[cmfd_pkg::RawBits-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == cmfd_pkg::DivCntW'(cmfd_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/can_motor_feedback_decoder_top.sv =====
`timescale 1ns / 1ps
// Motor feedback decoder: one CAN frame per input transfer, one result per frame.
// A status frame passes each of angle, speed and torque through a shared
// bit-serial multiplier and a bit-serial divider by the raw full scale, and a
// multi-turn step uses the multiplier once more. Ignored and error frames skip
// the arithmetic. A new frame is taken while the previous result still waits
// in the output register.
module can_motor_feedback_decoder_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cmfd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [cmfd_pkg::ConfW-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // frame_id, payload_front, payload_back, zero fill
  input  logic [cmfd_pkg::InDataW-1:0]       s_axis_tdata,
  // is_extended
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // angle, speed, torque, temperature_tenths, fault_code, enabled,
  // multi_turn_angle, zero fill
  output logic [cmfd_pkg::OutDataW-1:0]      m_axis_tdata,
  // frame_kind
  output logic [cmfd_pkg::KindW-1:0]         m_axis_tuser
);

  localparam int StW = 3;
  localparam logic [StW-1:0] StIdle   = 3'd0;
  localparam logic [StW-1:0] StDecode = 3'd1;
  localparam logic [StW-1:0] StMul    = 3'd2;
  localparam logic [StW-1:0] StDiv    = 3'd3;
  localparam logic [StW-1:0] StStep   = 3'd4;
  localparam logic [StW-1:0] StTurn   = 3'd5;
  localparam logic [StW-1:0] StWrite  = 3'd6;

  localparam logic [1:0] FldAngle  = 2'd0;
  localparam logic [1:0] FldSpeed  = 2'd1;
  localparam logic [1:0] FldTorque = 2'd2;

  localparam int CW = cmfd_pkg::ConfW;
  localparam int WW = cmfd_pkg::WordW;

  logic [StW-1:0]                    state_q, state_d;
  logic [1:0]                        fld_q, fld_d;
  logic [cmfd_pkg::KindW-1:0]        kind_q, kind_d;

  logic [cmfd_pkg::IdW-1:0]          id_q;
  logic                              ext_q;
  logic [WW-1:0]                     front_q, back_q;

  logic [7:0]                        motor_address_q;
  logic [CW-1:0]                     angle_min_q, angle_span_q;
  logic [CW-1:0]                     speed_min_q, speed_span_q;
  logic [CW-1:0]                     torque_min_q, torque_span_q;
  logic [CW-1:0]                     inv_gear_q;

  logic signed [CW-1:0]              angle_q, angle_d;
  logic signed [CW-1:0]              speed_q, speed_d;
  logic signed [CW-1:0]              torque_q, torque_d;
  logic [cmfd_pkg::TempW-1:0]        temp_q, temp_d;
  logic [CW-1:0]                     fault_q, fault_d;
  logic                              enabled_q, enabled_d;
  logic signed [CW-1:0]              prev_q, prev_d;
  logic                              prev_valid_q, prev_valid_d;
  logic [cmfd_pkg::AccW-1:0]         accum_q, accum_d;

  logic                              m_valid_q, m_valid_d;
  logic [cmfd_pkg::OutDataW-1:0]     m_data_q, m_data_d;
  logic [cmfd_pkg::KindW-1:0]        m_user_q, m_user_d;

  logic                              mul_start;
  logic signed [cmfd_pkg::MulAW-1:0] mul_a;
  logic [cmfd_pkg::MulBW-1:0]        mul_b;
  logic                              mul_done;
  logic signed [cmfd_pkg::MulPW-1:0] mul_prod;
  logic                              div_start;
  logic [cmfd_pkg::DivW-1:0]         div_dvd;
  logic                              div_done;
  logic [cmfd_pkg::DivW-1:0]         div_quot;

  logic [1:0]                        sel_fld;
  logic [15:0]                       raw16;
  logic [CW-1:0]                     sel_span;
  logic [CW-1:0]                     cur_min;
  logic signed [cmfd_pkg::ErrW-1:0]  mapped;
  logic signed [CW-1:0]              mapped_sat;
  logic                              match;
  logic                              is_status;
  logic                              is_error;
  logic [4:0]                        ftype;
  logic signed [CW-1:0]              prev_eff;
  logic signed [cmfd_pkg::ErrW-1:0]  err;
  logic signed [cmfd_pkg::ErrW-1:0]  stp;
  logic                              big;
  logic signed [cmfd_pkg::MulPW-1:0] shifted;
  logic                              s_fire;
  logic                              out_free;

  cmfd_mul_serial u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  cmfd_div_const u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign ftype     = id_q[28:24];
  assign match     = ext_q && (id_q[15:8] == motor_address_q);
  assign is_status = (ftype == cmfd_pkg::TypeStatusA) || (ftype == cmfd_pkg::TypeStatusB);
  assign is_error  = (ftype == cmfd_pkg::TypeError);

  // field whose multiplication starts this cycle
  assign sel_fld = (state_q == StDecode) ? FldAngle : fld_q + 2'd1;

  always_comb begin
    unique case (sel_fld)
      FldAngle: begin
        raw16    = front_q[31:16];
        sel_span = angle_span_q;
      end
      FldSpeed: begin
        raw16    = front_q[15:0];
        sel_span = speed_span_q;
      end
      FldTorque: begin
        raw16    = back_q[31:16];
        sel_span = torque_span_q;
      end
      default: begin
        raw16    = '0;
        sel_span = '0;
      end
    endcase
  end

  always_comb begin
    unique case (fld_q)
      FldAngle:  cur_min = angle_min_q;
      FldSpeed:  cur_min = speed_min_q;
      FldTorque: cur_min = torque_min_q;
      default:   cur_min = '0;
    endcase
  end

  // min + quotient, then saturate to the field range
  always_comb begin
    mapped = {{2{cur_min[CW-1]}}, cur_min} +
             {1'b0, div_quot[CW:0]};
    if (mapped[cmfd_pkg::ErrW-1:CW-1] == '0 ||
        mapped[cmfd_pkg::ErrW-1:CW-1] == '1) begin
      mapped_sat = mapped[CW-1:0];
    end else if (mapped[cmfd_pkg::ErrW-1]) begin
      mapped_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      mapped_sat = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_comb begin
    prev_eff = prev_valid_q ? prev_q : angle_q;
    err      = {{2{angle_q[CW-1]}}, angle_q} - {{2{prev_eff[CW-1]}}, prev_eff};
    big      = (err > cmfd_pkg::Dead) || (err < -cmfd_pkg::Dead);
    priority if (err < -cmfd_pkg::Pi) begin
      stp = err + cmfd_pkg::TwoPi;
    end else if (err > cmfd_pkg::Pi) begin
      stp = err - cmfd_pkg::TwoPi;
    end else begin
      stp = err;
    end
    shifted = mul_prod >>> cmfd_pkg::FracBits;
  end

  assign div_dvd = {1'b0, mul_prod[cmfd_pkg::RawBits+CW-1:0]} +
                   (cmfd_pkg::DivW'(1) << (cmfd_pkg::RawBits - 1));

  always_comb begin
    state_d      = state_q;
    fld_d        = fld_q;
    kind_d       = kind_q;
    angle_d      = angle_q;
    speed_d      = speed_q;
    torque_d     = torque_q;
    temp_d       = temp_q;
    fault_d      = fault_q;
    enabled_d    = enabled_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    accum_d      = accum_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    mul_start    = 1'b0;
    mul_a        = {2'b00, sel_span};
    mul_b        = cmfd_pkg::MulBW'(raw16[cmfd_pkg::RawBits-1:0]);
    div_start    = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (s_fire) begin
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (match && is_status) begin
          mul_start = 1'b1;
          fld_d     = FldAngle;
          state_d   = StMul;
        end else if (match && is_error) begin
          fault_d = {front_q[15:8], front_q[23:16], front_q[31:24]};
          kind_d  = cmfd_pkg::KindError;
          state_d = StWrite;
        end else begin
          kind_d  = cmfd_pkg::KindIgnored;
          state_d = StWrite;
        end
      end
      StMul: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          unique case (fld_q)
            FldAngle:  angle_d  = mapped_sat;
            FldSpeed:  speed_d  = mapped_sat;
            FldTorque: torque_d = mapped_sat;
            default:   angle_d  = angle_q;
          endcase
          if (fld_q == FldTorque) begin
            temp_d    = back_q[15:0];
            fault_d   = {{(CW-6){1'b0}}, id_q[21:16]};
            enabled_d = (id_q[23:22] == 2'b10);
            kind_d    = cmfd_pkg::KindStatus;
            state_d   = StStep;
          end else begin
            mul_start = 1'b1;
            fld_d     = sel_fld;
            state_d   = StMul;
          end
        end
      end
      StStep: begin
        if (big) begin
          mul_start = 1'b1;
          mul_a     = stp;
          mul_b     = inv_gear_q;
          state_d   = StTurn;
        end else begin
          prev_d       = angle_q;
          prev_valid_d = 1'b1;
          state_d      = StWrite;
        end
      end
      StTurn: begin
        if (mul_done) begin
          accum_d      = accum_q + shifted[cmfd_pkg::AccW-1:0];
          prev_d       = angle_q;
          prev_valid_d = 1'b1;
          state_d      = StWrite;
        end
      end
      StWrite: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {{(cmfd_pkg::OutDataW - cmfd_pkg::OutUsedW){1'b0}},
                       accum_q, enabled_q, fault_q, temp_q, torque_q, speed_q, angle_q};
          m_user_d  = kind_q;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      fld_q        <= FldAngle;
      kind_q       <= cmfd_pkg::KindIgnored;
      angle_q      <= '0;
      speed_q      <= '0;
      torque_q     <= '0;
      temp_q       <= '0;
      fault_q      <= '0;
      enabled_q    <= 1'b0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      accum_q      <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      fld_q        <= fld_d;
      kind_q       <= kind_d;
      angle_q      <= angle_d;
      speed_q      <= speed_d;
      torque_q     <= torque_d;
      temp_q       <= temp_d;
      fault_q      <= fault_d;
      enabled_q    <= enabled_d;
      prev_q       <= prev_d;
      prev_valid_q <= prev_valid_d;
      accum_q      <= accum_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    if (s_fire) begin
      id_q    <= s_axis_tdata[cmfd_pkg::IdW-1:0];
      front_q <= s_axis_tdata[cmfd_pkg::IdW+WW-1:cmfd_pkg::IdW];
      back_q  <= s_axis_tdata[cmfd_pkg::IdW+2*WW-1:cmfd_pkg::IdW+WW];
      ext_q   <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_address_q <= 8'd0;
      angle_min_q     <= CW'(-823788);
      angle_span_q    <= CW'(1647575);
      speed_min_q     <= CW'(-2162688);
      speed_span_q    <= CW'(4325376);
      torque_min_q    <= CW'(-917504);
      torque_span_q   <= CW'(1835008);
      inv_gear_q      <= CW'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cmfd_pkg::RegMotorAddress: motor_address_q <= cfg_data_i[7:0];
        cmfd_pkg::RegAngleMin:     angle_min_q     <= cfg_data_i;
        cmfd_pkg::RegAngleSpan:    angle_span_q    <= cfg_data_i;
        cmfd_pkg::RegSpeedMin:     speed_min_q     <= cfg_data_i;
        cmfd_pkg::RegSpeedSpan:    speed_span_q    <= cfg_data_i;
        cmfd_pkg::RegTorqueMin:    torque_min_q    <= cfg_data_i;
        cmfd_pkg::RegTorqueSpan:   torque_span_q   <= cfg_data_i;
        cmfd_pkg::RegInvGearRatio: inv_gear_q      <= cfg_data_i;
        default:                   inv_gear_q      <= inv_gear_q;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import cmfd_pkg::*;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic             ext;
    logic [WordW-1:0] front;
    logic [WordW-1:0] back;
  } can_frame_t;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic signed [ConfW-1:0] angle;
    logic signed [ConfW-1:0] speed;
    logic signed [ConfW-1:0] torque;
    logic [TempW-1:0]        temp;
    logic [ConfW-1:0]        fault;
    logic                    enabled;
    logic signed [AccW-1:0]  turns;
  } motor_fb_t;

  typedef struct packed {
    can_frame_t frame;
    logic       typed;
    motor_fb_t  fb;
  } dir_row_t;

  localparam logic [4:0] TypeParamRead = 5'h11;

  // pi, 2pi and the 0.01 rad deadband at 16 fraction bits
  localparam longint PiFx    = 205887;
  localparam longint TwoPiFx = 411775;
  localparam longint DeadFx  = 655;

  localparam motor_fb_t FbZero = '0;

  localparam int NumRows = 18;
  localparam dir_row_t DirRows [NumRows] = '{
    '{'{{TypeStatusA, 8'h80, 8'h00, 8'h00}, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, FbZero},
    '{'{{TypeStatusA, 8'h80, 8'h01, 8'h00}, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, FbZero},
    '{'{{TypeParamRead, 8'h80, 8'h00, 8'h00}, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0}, 1'b1,
      FbZero},
    '{'{{TypeError, 8'h00, 8'h00, 8'h00}, 1'b1, 32'hAABB_CCDD, 32'h0000_0000}, 1'b1,
      '{KindError, 24'sd0, 24'sd0, 24'sd0, 16'h0000, 24'hCCBBAA, 1'b0, 48'sd0}},
    '{'{{TypeStatusA, 8'hA5, 8'h00, 8'h00}, 1'b1, 32'h0000_0000, 32'h0000_FFFF}, 1'b1,
      '{KindStatus, -24'sd823788, -24'sd2162688, -24'sd917504, 16'hFFFF, 24'h000025, 1'b1,
        48'sd0}},
    '{'{{TypeStatusB, 8'h3F, 8'h00, 8'h00}, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, FbZero},
    '{'{{TypeStatusA, 8'h40, 8'h00, 8'h00}, 1'b1, 32'h8000_1234, 32'h7FFF_0190}, 1'b0, FbZero},
    '{'{{TypeStatusA, 8'hC1, 8'h00, 8'h5A}, 1'b1, 32'h800A_0000, 32'h0000_0000}, 1'b0, FbZero},
    '{'{{TypeStatusB, 8'h80, 8'h00, 8'hA5}, 1'b1, 32'h806E_FFFF, 32'hFFFF_0000}, 1'b0, FbZero},
    '{'{{TypeStatusA, 8'h80, 8'h00, 8'h00}, 1'b1, 32'h0000_8000, 32'h8000_0123}, 1'b0, FbZero},
    '{'{{TypeStatusA, 8'h80, 8'h00, 8'h00}, 1'b1, 32'hFFFF_0000, 32'h0001_0258}, 1'b0, FbZero},
    '{'{{TypeError, 8'h00, 8'h00, 8'h00}, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0, FbZero},
    '{'{{TypeError, 8'hFF, 8'h00, 8'hFF}, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, FbZero},
    '{'{29'h1FFF_FFFF, 1'b1, 32'h0000_0000, 32'h0000_0000}, 1'b0, FbZero},
    '{'{{TypeError, 8'h00, 8'h00, 8'h00}, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, FbZero},
    '{'{{TypeError, 8'h00, 8'h7F, 8'h00}, 1'b1, 32'h1234_5678, 32'h0000_0000}, 1'b0, FbZero},
    '{'{{TypeParamRead, 8'h80, 8'h00, 8'h00}, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0,
      FbZero},
    '{'{{TypeStatusA, 8'h80, 8'h00, 8'h00}, 1'b1, 32'hFFFF_5555, 32'h5555_AAAA}, 1'b0, FbZero}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [ConfW-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [KindW-1:0]     m_axis_tuser;

  // register shadows, reset values
  logic [7:0]       cfg_motor = 8'h00;
  logic [ConfW-1:0] cfg_angle_min = 24'(-823788);
  logic [ConfW-1:0] cfg_angle_span = 24'd1647575;
  logic [ConfW-1:0] cfg_speed_min = 24'(-2162688);
  logic [ConfW-1:0] cfg_speed_span = 24'd4325376;
  logic [ConfW-1:0] cfg_torque_min = 24'(-917504);
  logic [ConfW-1:0] cfg_torque_span = 24'd1835008;
  logic [ConfW-1:0] cfg_gear = 24'd65536;

  // decoder state
  motor_fb_t               fb_held = '0;
  logic signed [ConfW-1:0] prev_ang = '0;
  logic                    have_prev = 1'b0;

  motor_fb_t   fb_expected [$];
  int          fail_count = 0;
  int unsigned burst_left = 0;
  logic [15:0] last_raw = '0;
  bit          hold_rx = 1'b0;

  can_motor_feedback_decoder_top uut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(64'd25_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [ConfW-1:0] scale_raw(input logic [15:0] raw,
                                                       input logic [ConfW-1:0] lo,
                                                       input logic [ConfW-1:0] span);
    longint v;
    v = longint'(signed'(lo)) + (longint'(raw) * longint'(span) + 64'sd32768) / 64'sd65535;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return 24'(v);
  endfunction

  function automatic motor_fb_t decode_frame(input can_frame_t f);
    longint     err;
    longint     stp;
    logic [4:0] ftype;
    ftype = f.id[28:24];
    fb_held.kind = KindIgnored;
    if (f.ext && f.id[15:8] == cfg_motor) begin
      if (ftype == TypeStatusA || ftype == TypeStatusB) begin
        fb_held.angle = scale_raw(f.front[31:16], cfg_angle_min, cfg_angle_span);
        fb_held.speed = scale_raw(f.front[15:0], cfg_speed_min, cfg_speed_span);
        fb_held.torque = scale_raw(f.back[31:16], cfg_torque_min, cfg_torque_span);
        fb_held.temp = f.back[15:0];
        fb_held.fault = {18'b0, f.id[21:16]};
        fb_held.enabled = (f.id[23:22] == 2'b10);
        if (!have_prev) prev_ang = fb_held.angle;
        err = longint'(signed'(fb_held.angle)) - longint'(signed'(prev_ang));
        if (err > DeadFx || err < -DeadFx) begin
          stp = err;
          if (err < -PiFx) stp = stp + TwoPiFx;
          else if (err > PiFx) stp = stp - TwoPiFx;
          stp = (stp * longint'(cfg_gear)) >>> FracBits;
          fb_held.turns = fb_held.turns + stp[AccW-1:0];
        end
        prev_ang = fb_held.angle;
        have_prev = 1'b1;
        fb_held.kind = KindStatus;
      end else if (ftype == TypeError) begin
        fb_held.fault = {f.front[15:8], f.front[23:16], f.front[31:24]};
        fb_held.kind = KindError;
      end
    end
    return fb_held;
  endfunction

  function automatic can_frame_t random_frame();
    can_frame_t  f;
    int unsigned sel;
    logic [4:0]  ftype;
    logic [15:0] ang;
    f.id = IdW'($urandom);
    f.ext = 1'b1;
    f.front = $urandom;
    f.back = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      f.ext = 1'($urandom);
      return f;
    end
    f.id[15:8] = cfg_motor;
    if (sel < 50) ftype = TypeStatusA;
    else if (sel < 68) ftype = TypeStatusB;
    else if (sel < 82) ftype = TypeError;
    else if (sel < 87) ftype = TypeParamRead;
    else ftype = 5'($urandom);
    f.id[28:24] = ftype;
    if (sel >= 93) begin
      if (sel[0]) f.ext = 1'b0;
      else f.id[15:8] = cfg_motor ^ 8'($urandom_range(1, 255));
    end
    if (ftype == TypeStatusA || ftype == TypeStatusB) begin
      case ($urandom_range(0, 3))
        0: ang = last_raw + 16'($urandom_range(0, 128)) - 16'd64;
        1: ang = last_raw + 16'($urandom_range(0, 8000)) - 16'd4000;
        2: ang = last_raw + 16'($urandom_range(0, 60000)) - 16'd30000;
        default: ang = 16'($urandom);
      endcase
      f.front[31:16] = ang;
      last_raw = ang;
    end
    return f;
  endfunction

  task automatic push_frame(input can_frame_t f, input logic typed, input motor_fb_t fb);
    motor_fb_t predicted;
    s_axis_tdata = {3'b000, f.back, f.front, f.id};
    s_axis_tuser = f.ext;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = decode_frame(f);
    fb_expected.push_back(typed ? fb : predicted);
    @(negedge clk_i);
  endtask

  // sender runs in bursts with gaps between them
  task automatic offer(input can_frame_t f, input logic typed, input motor_fb_t fb);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push_frame(f, typed, fb);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (fb_expected.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ConfW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    case (idx)
      RegMotorAddress: cfg_motor = val[7:0];
      RegAngleMin:     cfg_angle_min = val;
      RegAngleSpan:    cfg_angle_span = val;
      RegSpeedMin:     cfg_speed_min = val;
      RegSpeedSpan:    cfg_speed_span = val;
      RegTorqueMin:    cfg_torque_min = val;
      RegTorqueSpan:   cfg_torque_span = val;
      RegInvGearRatio: cfg_gear = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    motor_fb_t got;
    motor_fb_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.angle = m_axis_tdata[23:0];
      got.speed = m_axis_tdata[47:24];
      got.torque = m_axis_tdata[71:48];
      got.temp = m_axis_tdata[87:72];
      got.fault = m_axis_tdata[111:88];
      got.enabled = m_axis_tdata[112];
      got.turns = m_axis_tdata[160:113];
      if (fb_expected.size() == 0) begin
        $display("%0t: result transfer with nothing pending, expected none, actual kind %0d",
                 $time, got.kind);
        fail_count++;
      end else begin
        want = fb_expected.pop_front();
        check_field("frame_kind", want.kind, got.kind);
        check_field("angle", want.angle, got.angle);
        check_field("speed", want.speed, got.speed);
        check_field("torque", want.torque, got.torque);
        check_field("temperature", want.temp, got.temp);
        check_field("fault_code", want.fault, got.fault);
        check_field("enabled", want.enabled, got.enabled);
        check_field("multi_turn_angle", want.turns, got.turns);
      end
    end
  end

  // receiver stall patterns, plus one long hold-off on request
  initial begin
    int unsigned rx_mode;
    int unsigned rx_left;
    rx_mode = 0;
    rx_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready = 1'b0;
        repeat (1500) @(negedge clk_i);
        hold_rx = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = ($urandom_range(0, 3) != 0);
          2: m_axis_tready = 1'($urandom_range(0, 1));
          default: m_axis_tready = ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [ConfW-1:0] setting [8];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (DirRows[r]) begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) @(negedge clk_i);
      push_frame(DirRows[r].frame, DirRows[r].typed, DirRows[r].fb);
      s_axis_tvalid = 1'b0;
    end
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          setting[RegMotorAddress] = 24'hFF;
          setting[RegAngleMin] = 24'h7FFFFF;
          setting[RegAngleSpan] = 24'hFFFFFF;
          setting[RegSpeedMin] = 24'h800000;
          setting[RegSpeedSpan] = 24'h000000;
          setting[RegTorqueMin] = 24'h000000;
          setting[RegTorqueSpan] = 24'hFFFFFF;
          setting[RegInvGearRatio] = 24'hFFFFFF;
        end
        1: begin
          setting[RegMotorAddress] = 24'h00;
          setting[RegAngleMin] = 24'h800000;
          setting[RegAngleSpan] = 24'h000000;
          setting[RegSpeedMin] = 24'h7FFFFF;
          setting[RegSpeedSpan] = 24'hFFFFFF;
          setting[RegTorqueMin] = 24'h800000;
          setting[RegTorqueSpan] = 24'hFFFFFF;
          setting[RegInvGearRatio] = 24'h000000;
        end
        default: begin
          setting[RegMotorAddress] = 24'($urandom_range(0, 255));
          setting[RegAngleMin] = 24'(-823788);
          setting[RegAngleSpan] = 24'd1647575;
          setting[RegSpeedMin] = 24'(-2162688);
          setting[RegSpeedSpan] = 24'd4325376;
          setting[RegTorqueMin] = 24'(-917504);
          setting[RegTorqueSpan] = 24'd1835008;
          setting[RegInvGearRatio] = 24'($urandom_range(0, 200000));
          if (ph > 2) begin
            for (int i = 1; i < 8; i++) begin
              if ($urandom_range(0, 1) == 0) setting[i] = 24'($urandom);
            end
          end
        end
      endcase
      for (int i = 0; i < 8; i++) write_reg(CfgIdxW'(i), setting[i]);
      cfg_we_i = 1'b0;
      if (ph == 2) hold_rx = 1'b1;
      for (int n = 0; n < 150; n++) begin
        if (ph == 4 && n == 75) wait_idle();
        offer(random_frame(), 1'b0, FbZero);
      end
      wait_idle();
    end

    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
